// ===== src/topo_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Topological order package
// Shared constants, the control state type and the node cell control bundle.
// ----------------------------------------------------------------------------
package topo_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = 5;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_ALIGN,
    ST_EMIT,
    ST_LOOP
  } topo_state_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
    logic             start;
    logic             scan;
    logic             clear;
  } topo_ctl_t;

endpackage

`default_nettype wire

// ===== src/topo_node_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Node cell
// Holds the incoming edges and the taken flag of one node and passes the
// scan token to its neighbor.
// ----------------------------------------------------------------------------
module topo_node_cell #(
  parameter int MAX_NODES = 16,
  parameter int CELL_IDX  = 0
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire topo_pkg::topo_ctl_t ctl,
  input  wire                     tok_in,
  input  wire [MAX_NODES-1:0]     taken_all,
  input  wire [MAX_NODES-1:0]     act,
  output logic                    tok,
  output logic                    taken,
  output logic                    took
);
  import topo_pkg::*;

  logic [MAX_NODES-1:0] in_mask_r, in_mask_nxt;
  logic                 taken_r, taken_nxt;
  logic                 tok_r;
  logic [MAX_NODES-1:0] pend;
  logic                 ready;

  always_comb begin
    pend  = in_mask_r & ~taken_all & act;
    ready = ~taken_r & ~(|pend);
    took  = ctl.scan & tok_r & ready;

    in_mask_nxt = in_mask_r;
    if (ctl.clear) begin
      in_mask_nxt = '0;
    end else if (ctl.load && (int'(ctl.dst) == CELL_IDX)) begin
      for (int u = 0; u < MAX_NODES; u++) begin
        if (int'(ctl.src) == u) begin
          in_mask_nxt[u] = 1'b1;
        end
      end
    end

    taken_nxt = taken_r;
    if (ctl.start) begin
      taken_nxt = 1'b0;
    end else if (took) begin
      taken_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_mask_r <= '0;
      taken_r   <= 1'b0;
      tok_r     <= 1'b0;
    end else begin
      in_mask_r <= in_mask_nxt;
      taken_r   <= taken_nxt;
      tok_r     <= tok_in;
    end
  end

  assign tok   = tok_r;
  assign taken = taken_r;

endmodule

`default_nettype wire

// ===== src/topo_order_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Order cell
// One slot of the shift chain that collects the node order and moves it
// toward the output.
// ----------------------------------------------------------------------------
module topo_order_cell (
  input  wire                          clk,
  input  wire                          shift,
  input  wire  [topo_pkg::IDX_W-1:0]   d_in,
  output logic [topo_pkg::IDX_W-1:0]   q
);
  import topo_pkg::*;

  logic [IDX_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== src/topological_order_with_loop_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Topological order with loop check
// Collects a directed graph edge by edge and emits its nodes in Kahn order.
// ----------------------------------------------------------------------------
// Edges are loaded one item per cycle. The item with tlast closes the graph;
// the block then stops taking items and a scan token walks the row of node
// cells, one node per cycle, in passes over nodes 0 to n-1. A node is taken
// when none of its sources is still pending, and it counts as gone for the
// very next node. After the ordering passes the collected order is shifted to
// the output, then n results follow, one per cycle while the sink is ready.
// A graph with a cycle gives one result with tuser set instead. The edge
// store is empty again for the next graph.
module topological_order_with_loop_check #(
  parameter int MAX_NODES = topo_pkg::MAX_NODES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_wr_en,
  input  wire  [4:0] cfg_wr_data,   // node_count
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,      // [3:0] src_node, [7:4] dst_node
  input  wire        in_tuser,      // has_edge
  input  wire        in_tlast,      // last_edge
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,     // [3:0] node_index, [7:4] zero
  output logic       out_tuser,     // loop_found
  output logic       out_tlast      // is_last
);
  import topo_pkg::*;

  localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  topo_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] node_count_r;
  logic [CW-1:0]    done_r, done_nxt;
  logic             prog_r, prog_nxt;
  logic [CW-1:0]    n_act;

  topo_ctl_t            ctl;
  logic [MAX_NODES-1:0] tok_vec, tok_in, taken_vec, took_vec, act, last_oh;
  logic                 take, at_last, finish, loop_det, in_acc, out_acc, shift;
  logic [NW-1:0]        sel_idx;
  logic [IDX_W-1:0]     ord_q [MAX_NODES+1];

  always_comb begin
    if (node_count_r == '0) begin
      n_act = CW'(1);
    end else if (int'(node_count_r) > MAX_NODES) begin
      n_act = CW'(MAX_NODES);
    end else begin
      n_act = CW'(node_count_r);
    end
    for (int v = 0; v < MAX_NODES; v++) begin
      act[v]     = (v < int'(n_act));
      last_oh[v] = (v == int'(n_act) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  always_comb begin
    sel_idx = '0;
    for (int v = 0; v < MAX_NODES; v++) begin
      if (took_vec[v]) begin
        sel_idx = sel_idx | NW'(v);
      end
    end
    take     = |took_vec;
    at_last  = |(tok_vec & last_oh);
    finish   = (state_r == ST_SCAN) && take && (done_r + CW'(1) == n_act);
    loop_det = (state_r == ST_SCAN) && at_last && !take && !prog_r;
  end

  always_comb begin
    ctl.load  = in_acc & in_tuser;
    ctl.src   = in_tdata[3:0];
    ctl.dst   = in_tdata[7:4];
    ctl.start = in_acc & in_tlast;
    ctl.scan  = (state_r == ST_SCAN);
    ctl.clear = finish | loop_det;

    tok_in    = '0;
    tok_in[0] = ctl.start |
                ((state_r == ST_SCAN) && at_last && !finish && !loop_det);
    for (int v = 1; v < MAX_NODES; v++) begin
      tok_in[v] = (state_r == ST_SCAN) && tok_vec[v-1] && act[v] && !finish;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    done_nxt   = done_r;
    prog_nxt   = prog_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    out_tlast  = 1'b0;
    out_tuser  = 1'b0;
    out_tdata  = '0;
    shift      = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (ctl.start) begin
          state_nxt = ST_SCAN;
          done_nxt  = '0;
          prog_nxt  = 1'b0;
        end
      end
      ST_SCAN: begin
        shift = take;
        if (take) begin
          done_nxt = done_r + CW'(1);
          prog_nxt = 1'b1;
        end
        if (finish) begin
          if (done_r + CW'(1) == CW'(MAX_NODES)) begin
            state_nxt = ST_EMIT;
            done_nxt  = '0;
          end else begin
            state_nxt = ST_ALIGN;
          end
        end else if (loop_det) begin
          state_nxt = ST_LOOP;
        end else if (at_last) begin
          prog_nxt = 1'b0;
        end
      end
      ST_ALIGN: begin
        shift    = 1'b1;
        done_nxt = done_r + CW'(1);
        if (done_r == CW'(MAX_NODES - 1)) begin
          state_nxt = ST_EMIT;
          done_nxt  = '0;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        out_tdata  = {4'b0000, ord_q[0]};
        out_tlast  = (done_r + CW'(1) == n_act);
        shift      = out_acc;
        if (out_acc) begin
          done_nxt = done_r + CW'(1);
          if (out_tlast) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOOP: begin
        out_tvalid = 1'b1;
        out_tlast  = 1'b1;
        out_tuser  = 1'b1;
        if (out_acc) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      done_r  <= '0;
      prog_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      prog_r  <= prog_nxt;
    end
  end

  for (genvar v = 0; v < MAX_NODES; v++) begin : g_node
    topo_node_cell #(
      .MAX_NODES (MAX_NODES),
      .CELL_IDX  (v)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .tok_in    (tok_in[v]),
      .taken_all (taken_vec),
      .act       (act),
      .tok       (tok_vec[v]),
      .taken     (taken_vec[v]),
      .took      (took_vec[v])
    );
  end

  assign ord_q[MAX_NODES] = IDX_W'(sel_idx);

  for (genvar i = 0; i < MAX_NODES; i++) begin : g_order
    topo_order_cell u_ord (
      .clk   (clk),
      .shift (shift),
      .d_in  (ord_q[i+1]),
      .q     (ord_q[i])
    );
  end

endmodule

`default_nettype wire
